@@ hdl/urq_pkg.sv @@
// ---------------------------------------------------------------------------
// urq_pkg
// Shared widths, register indexes, reset values and state codes for the
// ultrasonic range qualifier.
// ---------------------------------------------------------------------------
package urq_pkg;

  localparam int PULSE_W = 16;
  localparam int TPC_W   = 8;
  localparam int CM_W    = 10;
  localparam int SAMPLES = 3;

  localparam logic [7:0]      ECHO_MARGIN = 8'd200;
  localparam logic [CM_W-1:0] MIN_CM      = 10'd2;

  typedef enum logic [2:0] {
    CFG_ENABLE       = 3'd0,
    CFG_TICKS_PER_CM = 3'd1,
    CFG_MAX_RANGE    = 3'd2,
    CFG_MAX_CHANGE   = 3'd3,
    CFG_BAND_LOW     = 3'd4,
    CFG_BAND_HIGH    = 3'd5,
    CFG_SPREAD       = 3'd6,
    CFG_MIN_PULSE    = 3'd7
  } cfg_idx_t;

  localparam logic [TPC_W-1:0]   RST_TICKS_PER_CM = 8'd58;
  localparam logic [CM_W-1:0]    RST_MAX_RANGE    = 10'd250;
  localparam logic [CM_W-1:0]    RST_MAX_CHANGE   = 10'd350;
  localparam logic [CM_W-1:0]    RST_BAND_LOW     = 10'd76;
  localparam logic [CM_W-1:0]    RST_BAND_HIGH    = 10'd80;
  localparam logic [CM_W-1:0]    RST_SPREAD       = 10'd30;
  localparam logic [PULSE_W-1:0] RST_MIN_PULSE    = 16'd116;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_KEEP = 7'b0000010,
    ST_SEL  = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_DEC  = 7'b0010000,
    ST_MED  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

endpackage

@@ hdl/urq_div.sv @@
// ---------------------------------------------------------------------------
// urq_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ---------------------------------------------------------------------------
module urq_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [urq_pkg::PULSE_W-1:0] dividend,
  input  logic [urq_pkg::TPC_W-1:0]   divisor,
  output logic                        done,
  output logic [urq_pkg::PULSE_W-1:0] quotient
);

  localparam int PW = urq_pkg::PULSE_W;
  localparam int DW = urq_pkg::TPC_W;
  localparam int CW = $clog2(PW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [PW-1:0] quo_r;
  logic [DW-1:0] div_r;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[PW-1]};
    diff    = trial - {1'b0, div_r};
    ge      = (trial >= {1'b0, div_r});
    // remainder always stays below the divisor
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CW'(PW - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(PW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[PW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ hdl/ultrasonic_range_qualifier_top.sv @@
// ---------------------------------------------------------------------------
// ultrasonic_range_qualifier_top
// Qualifies three echo pulses per beat into a filtered per-channel distance.
// ---------------------------------------------------------------------------
// Flow: a beat passes the keep, select, divide, decide and output states;
//   a median search follows the decide state when the ring wraps; items
//   that need no division (disabled, nothing kept, cluster) skip to output.
// Throughput: one item at a time; the next beat is taken only once the
//   previous result has been loaded into the output register.
// Reset (rst_n, synchronous): registers return to defaults, every channel's
//   ring, position and last distance clear to zero; no clearing pass.
module ultrasonic_range_qualifier_top #(
  parameter int RING_DEPTH = 5,
  parameter int CHANNELS   = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_channel,
  input  logic [15:0] in_pulse_a,
  input  logic [15:0] in_pulse_b,
  input  logic [15:0] in_pulse_c,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_channel,
  output logic        out_detected,
  output logic [9:0]  out_distance_cm,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int PLW   = urq_pkg::PULSE_W;
  localparam int TW    = urq_pkg::TPC_W;
  localparam int CMW   = urq_pkg::CM_W;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW    = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int MED_K = RING_DEPTH / 2;

  // configuration registers
  logic           enable_r;
  logic [TW-1:0]  tpc_r;
  logic [CMW-1:0] max_range_r;
  logic [CMW-1:0] max_change_r;
  logic [CMW-1:0] band_low_r;
  logic [CMW-1:0] band_high_r;
  logic [CMW-1:0] spread_r;
  logic [PLW-1:0] min_pulse_r;

  // channel state
  logic [CMW-1:0] ring_r [CHANNELS][RING_DEPTH];
  logic [PW-1:0]  pos_r  [CHANNELS];
  logic [CMW-1:0] last_r [CHANNELS];

  // item in flight
  urq_pkg::state_t state_r, state_nxt;
  logic           ch_r;
  logic [PLW-1:0] pa_r, pb_r, pc_r;
  logic [2:0]     keep_r;
  logic [CMW-1:0] wrow_r [RING_DEPTH];
  logic [PW-1:0]  med_idx_r;
  logic           res_det_r;
  logic [CMW-1:0] res_dist_r;

  logic           out_valid_r;
  logic           out_channel_r;
  logic           out_det_r;
  logic [CMW-1:0] out_dist_r;

  logic [CH_W-1:0] chi;
  logic            ch_ok;
  logic [TW-1:0]   tpc_eff;
  logic            accept;
  logic            out_load;

  // keep stage
  logic [18:0] timeout;
  logic [2:0]  keep_c;

  // select stage
  logic [1:0]     n_kept;
  logic [17:0]    sum;
  logic [PLW-1:0] lo, hi, mid;
  logic [17:0]    mid_w;
  logic [17:0]    band_lo_t;
  logic [18:0]    band_hi_t;
  logic           cluster;
  logic [PLW-1:0] ticks;

  // decide stage
  logic [PLW-1:0] q;
  logic           div_done;
  logic           div_start;
  logic [CMW-1:0] dist_cm;
  logic           too_far;
  logic [CMW-1:0] last;
  logic [CNT_W-1:0] zeros;
  logic           mostly_miss;
  logic           in_band;
  logic [CMW-1:0] diff;
  logic [PW-1:0]  pos;
  logic [PW-1:0]  pos_next;

  // median search
  logic [CMW-1:0]   cand;
  logic [CNT_W-1:0] n_less, n_eq;
  logic             med_found;

  assign chi       = CH_W'(ch_r);
  assign ch_ok     = ((CH_W + 1)'(ch_r) < (CH_W + 1)'(CHANNELS));
  assign tpc_eff   = (tpc_r == '0) ? TW'(1) : tpc_r;
  assign in_stall  = (state_r != urq_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == urq_pkg::ST_OUT) && (!out_valid_r || !out_stall);

  // configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      tpc_r        <= urq_pkg::RST_TICKS_PER_CM;
      max_range_r  <= urq_pkg::RST_MAX_RANGE;
      max_change_r <= urq_pkg::RST_MAX_CHANGE;
      band_low_r   <= urq_pkg::RST_BAND_LOW;
      band_high_r  <= urq_pkg::RST_BAND_HIGH;
      spread_r     <= urq_pkg::RST_SPREAD;
      min_pulse_r  <= urq_pkg::RST_MIN_PULSE;
    end else if (cfg_valid && cfg_ready) begin
      case (urq_pkg::cfg_idx_t'(cfg_index))
        urq_pkg::CFG_ENABLE:       enable_r     <= cfg_data[0];
        urq_pkg::CFG_TICKS_PER_CM: tpc_r        <= cfg_data[TW-1:0];
        urq_pkg::CFG_MAX_RANGE:    max_range_r  <= cfg_data[CMW-1:0];
        urq_pkg::CFG_MAX_CHANGE:   max_change_r <= cfg_data[CMW-1:0];
        urq_pkg::CFG_BAND_LOW:     band_low_r   <= cfg_data[CMW-1:0];
        urq_pkg::CFG_BAND_HIGH:    band_high_r  <= cfg_data[CMW-1:0];
        urq_pkg::CFG_SPREAD:       spread_r     <= cfg_data[CMW-1:0];
        urq_pkg::CFG_MIN_PULSE:    min_pulse_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // keep stage: pulse window check
  always_comb begin
    timeout   = 19'(18'(max_range_r) * 18'(tpc_eff)) + 19'(urq_pkg::ECHO_MARGIN);
    keep_c[0] = (pa_r != '0) && (pa_r >= min_pulse_r) && (19'(pa_r) <= timeout)
                && (urq_pkg::SAMPLES > 0);
    keep_c[1] = (pb_r != '0) && (pb_r >= min_pulse_r) && (19'(pb_r) <= timeout)
                && (urq_pkg::SAMPLES > 1);
    keep_c[2] = (pc_r != '0) && (pc_r >= min_pulse_r) && (19'(pc_r) <= timeout)
                && (urq_pkg::SAMPLES > 2);
  end

  // select stage: median of three or average of fewer
  always_comb begin
    n_kept = 2'($countones(keep_r));
    sum    = (keep_r[0] ? 18'(pa_r) : 18'd0) + (keep_r[1] ? 18'(pb_r) : 18'd0)
           + (keep_r[2] ? 18'(pc_r) : 18'd0);
    lo     = (pa_r < pb_r) ? pa_r : pb_r;
    hi     = (pa_r > pb_r) ? pa_r : pb_r;
    if (pc_r < lo) lo = pc_r;
    if (pc_r > hi) hi = pc_r;
    mid_w  = 18'(pa_r) + 18'(pb_r) + 18'(pc_r) - 18'(lo) - 18'(hi);
    mid    = mid_w[PLW-1:0];
    // floor(x/t) >= B  <=>  x >= B*t ;  floor(x/t) <= B  <=>  x < (B+1)*t
    band_lo_t = 18'(band_low_r) * 18'(tpc_eff);
    band_hi_t = (19'(band_high_r) + 19'd1) * 19'(tpc_eff);
    cluster   = (n_kept == 2'd3) && (18'(lo) >= band_lo_t) && (19'(hi) < band_hi_t)
                && ((hi - lo) < PLW'(spread_r));
    case (n_kept)
      2'd3:    ticks = mid;
      2'd2:    ticks = sum[PLW:1];
      default: ticks = sum[PLW-1:0];
    endcase
  end

  assign div_start = (state_r == urq_pkg::ST_SEL) && enable_r && ch_ok
                     && (n_kept != 2'd0) && !cluster;

  urq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ticks),
    .divisor  (tpc_eff),
    .done     (div_done),
    .quotient (q)
  );

  // decide stage
  always_comb begin
    too_far = 1'b0;
    if (q < PLW'(urq_pkg::MIN_CM)) begin
      dist_cm = urq_pkg::MIN_CM;
    end else begin
      dist_cm = q[CMW-1:0];
      too_far = (q > PLW'(max_range_r));
    end
    last  = last_r[chi];
    zeros = '0;
    for (int j = 0; j < RING_DEPTH; j++) begin
      if (wrow_r[j] == '0) zeros = zeros + CNT_W'(1);
    end
    mostly_miss = ({1'b0, zeros, 1'b0} > (CNT_W + 2)'(RING_DEPTH));
    in_band     = (dist_cm >= band_low_r) && (dist_cm <= band_high_r);
    diff        = (dist_cm > last) ? dist_cm - last : last - dist_cm;
    pos         = pos_r[chi];
    pos_next    = (pos == PW'(RING_DEPTH - 1)) ? '0 : pos + PW'(1);
  end

  // median: the entry whose rank range covers the middle slot
  always_comb begin
    cand   = wrow_r[med_idx_r];
    n_less = '0;
    n_eq   = '0;
    for (int j = 0; j < RING_DEPTH; j++) begin
      if (wrow_r[j] < cand)  n_less = n_less + CNT_W'(1);
      if (wrow_r[j] == cand) n_eq   = n_eq + CNT_W'(1);
    end
    med_found = (n_less <= CNT_W'(MED_K)) && (CNT_W'(MED_K) < n_less + n_eq);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      urq_pkg::ST_IDLE: if (accept) state_nxt = urq_pkg::ST_KEEP;
      urq_pkg::ST_KEEP: state_nxt = urq_pkg::ST_SEL;
      urq_pkg::ST_SEL:  state_nxt = div_start ? urq_pkg::ST_DIV : urq_pkg::ST_OUT;
      urq_pkg::ST_DIV:  if (div_done) state_nxt = urq_pkg::ST_DEC;
      urq_pkg::ST_DEC: begin
        if (!too_far && !(in_band && (last == '0 || mostly_miss))
            && !(last != '0 && diff > max_change_r) && pos_next == '0) begin
          state_nxt = urq_pkg::ST_MED;
        end else begin
          state_nxt = urq_pkg::ST_OUT;
        end
      end
      urq_pkg::ST_MED:  if (med_found) state_nxt = urq_pkg::ST_OUT;
      urq_pkg::ST_OUT:  if (out_load) state_nxt = urq_pkg::ST_IDLE;
      default:          state_nxt = urq_pkg::ST_IDLE;
    endcase
  end

  // control and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= urq_pkg::ST_IDLE;
      for (int c = 0; c < CHANNELS; c++) begin
        pos_r[c]  <= '0;
        last_r[c] <= '0;
        for (int j = 0; j < RING_DEPTH; j++) ring_r[c][j] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == urq_pkg::ST_SEL && enable_r && ch_ok
          && (n_kept == 2'd0 || cluster)) begin
        pos_r[chi]  <= '0;
        last_r[chi] <= '0;
        for (int j = 0; j < RING_DEPTH; j++) ring_r[chi][j] <= '0;
      end
      if (state_r == urq_pkg::ST_DEC) begin
        if (too_far) begin
          pos_r[chi]  <= '0;
          last_r[chi] <= '0;
          for (int j = 0; j < RING_DEPTH; j++) ring_r[chi][j] <= '0;
        end else if (!(in_band && (last == '0 || mostly_miss))
                     && !(last != '0 && diff > max_change_r)) begin
          last_r[chi]      <= dist_cm;
          ring_r[chi][pos] <= dist_cm;
          pos_r[chi]       <= pos_next;
        end
      end
    end
  end

  // item payload and result
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r <= in_channel;
      pa_r <= in_pulse_a;
      pb_r <= in_pulse_b;
      pc_r <= in_pulse_c;
    end
    case (state_r)
      urq_pkg::ST_KEEP: begin
        keep_r <= keep_c;
        for (int j = 0; j < RING_DEPTH; j++) wrow_r[j] <= ring_r[chi][j];
      end
      urq_pkg::ST_SEL: begin
        res_det_r  <= 1'b0;
        res_dist_r <= '0;
      end
      urq_pkg::ST_DEC: begin
        med_idx_r <= '0;
        if (!too_far && !(in_band && (last == '0 || mostly_miss))) begin
          res_det_r <= 1'b1;
          if (last != '0 && diff > max_change_r) begin
            res_dist_r <= last;
          end else begin
            res_dist_r  <= dist_cm;
            wrow_r[pos] <= dist_cm;
          end
        end else begin
          res_det_r  <= 1'b0;
          res_dist_r <= '0;
        end
      end
      urq_pkg::ST_MED: begin
        med_idx_r <= med_idx_r + PW'(1);
        if (med_found) begin
          res_det_r  <= 1'b1;
          res_dist_r <= cand;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel_r <= ch_r;
      out_det_r     <= res_det_r;
      out_dist_r    <= res_dist_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel     = out_channel_r;
  assign out_detected    = out_det_r;
  assign out_distance_cm = out_dist_r;

endmodule

@@ hdl/urq_checker.sv @@
// ---------------------------------------------------------------------------
// urq_checker
// Port-level checks on the range qualifier, bound to the top level.
// ---------------------------------------------------------------------------
module urq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_detected,
  input logic [9:0]  out_distance_cm
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance_cm))
    else $error("result beat dropped while stalled");

  // one item at a time: input stalls right after a beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while item in flight");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_detected |-> out_distance_cm == 10'd0)
    else $error("no detection with nonzero distance");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_detected |-> out_distance_cm >= 10'd2)
    else $error("detection below minimum distance");

endmodule

bind ultrasonic_range_qualifier_top urq_checker u_urq_checker (.*);
